>>> hw/rtl/crcbse_pkg.sv
// ----------------------------------------------------------------------------
// crcbse_pkg
// Shared constants, types and the byte division step for the CRC-16 engine.
// ----------------------------------------------------------------------------
package crcbse_pkg;

  localparam int unsigned CrcWidth  = 16;
  localparam int unsigned ByteWidth = 8;

  localparam logic [CrcWidth-1:0]  CrcPoly    = 16'h1021;
  localparam logic [CrcWidth-1:0]  CrcTopBit  = 16'h8000;
  localparam logic [ByteWidth-1:0] ByteTopBit = 8'h80;
  localparam logic [CrcWidth-1:0]  CrcLsb     = 16'h0001;

  typedef logic [CrcWidth-1:0]  crc_t;
  typedef logic [ByteWidth-1:0] byte_t;

  typedef struct packed {
    crc_t crc_value;
    logic crc_is_zero;
  } res_t;

  // Divide one byte into the remainder, MSB first, no augmentation.
  function automatic crc_t divide_byte(crc_t rem, byte_t data);
    crc_t  r;
    byte_t d;
    logic  carry;
    r = rem;
    d = data;
    for (int k = 0; k < ByteWidth; k++) begin
      carry = (r & CrcTopBit) != '0;
      r = r << 1;
      if (carry) begin
        r = r ^ CrcPoly;
      end
      if ((d & ByteTopBit) != '0) begin
        r = r ^ CrcLsb;
      end
      d = d << 1;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/crcbse_if.sv
// ----------------------------------------------------------------------------
// crcbse_if
// Valid/ready channels for the byte stream and the CRC results.
// ----------------------------------------------------------------------------
interface crcbse_in_if;
  logic                 valid;
  logic                 ready;
  crcbse_pkg::byte_t    data_byte;
  logic                 start_flag;
  logic                 last_byte;

  modport source (output valid, output data_byte, output start_flag, output last_byte,
                  input ready);
  modport sink (input valid, input data_byte, input start_flag, input last_byte,
                output ready);
endinterface

interface crcbse_out_if;
  logic                 valid;
  logic                 ready;
  crcbse_pkg::crc_t     crc_value;
  logic                 crc_is_zero;

  modport source (output valid, output crc_value, output crc_is_zero, input ready);
  modport sink (input valid, input crc_value, input crc_is_zero, output ready);
endinterface

>>> hw/rtl/crcbse_core.sv
// ----------------------------------------------------------------------------
// crcbse_core
// Input register, running remainder and combinational byte division.
// ----------------------------------------------------------------------------
module crcbse_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  crcbse_pkg::byte_t   in_data_i,
  input  logic                in_start_i,
  input  logic                in_last_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output crcbse_pkg::res_t    res_o
);

  logic              s1_valid_q, s1_valid_d;
  crcbse_pkg::byte_t s1_data_q;
  logic              s1_start_q;
  logic              s1_last_q;
  crcbse_pkg::crc_t  crc_q, crc_d;
  crcbse_pkg::crc_t  crc_base;
  logic              s1_adv;
  logic              in_xfer;

  // Advance when the byte yields no result or the result register takes it.
  assign s1_adv     = s1_valid_q && (!s1_last_q || res_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign crc_base = s1_start_q ? '0 : crc_q;
  assign crc_d    = crcbse_pkg::divide_byte(crc_base, s1_data_q);

  assign res_valid_o       = s1_valid_q && s1_last_q;
  assign res_o.crc_value   = crc_d;
  assign res_o.crc_is_zero = (crc_d == '0);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      crc_q      <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (s1_adv) begin
        crc_q <= crc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_data_q  <= in_data_i;
      s1_start_q <= in_start_i;
      s1_last_q  <= in_last_i;
    end
  end

endmodule

>>> hw/rtl/crcbse_out_reg.sv
// ----------------------------------------------------------------------------
// crcbse_out_reg
// Result register holding one CRC result until its transfer.
// ----------------------------------------------------------------------------
module crcbse_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             res_valid_i,
  output logic             res_ready_o,
  input  crcbse_pkg::res_t res_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output crcbse_pkg::res_t out_o
);

  logic             valid_q;
  crcbse_pkg::res_t res_q;

  assign res_ready_o = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

>>> hw/rtl/crc16_byte_stream_engine.sv
// ----------------------------------------------------------------------------
// crc16_byte_stream_engine
// CRC-16 (poly 0x1021) plain division over a byte stream, MSB first.
//
//   channel  dir  payload                       transfer when
//   in_i     in   data_byte, start_flag,        valid && ready
//                 last_byte
//   out_o    out  crc_value, crc_is_zero        valid && ready
//
// One byte per cycle sustained; the eight division steps sit between the
// input register and the running remainder; each result is then registered.
// Reset clears the remainder to zero and empties both registers.
// A stalled result holds in the output register while the next byte is taken;
// bytes stall only when a last byte cannot hand its result on.
// ----------------------------------------------------------------------------
module crc16_byte_stream_engine (
  input  logic   clk_i,
  input  logic   rst_ni,
  crcbse_in_if.sink    in_i,
  crcbse_out_if.source out_o
);

  logic             res_valid;
  logic             res_ready;
  crcbse_pkg::res_t res;
  crcbse_pkg::res_t out_res;

  crcbse_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_data_i   (in_i.data_byte),
    .in_start_i  (in_i.start_flag),
    .in_last_i   (in_i.last_byte),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  crcbse_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_o       (out_res)
  );

  assign out_o.crc_value   = out_res.crc_value;
  assign out_o.crc_is_zero = out_res.crc_is_zero;

endmodule

>>> bench/crc16_byte_stream_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_byte_stream_engine_test
// Self-checking bench for the CRC-16 byte stream engine. Directed bytes and
// random messages are sent; a local remainder predicts each result, and the
// results are checked in order under random and long output stalls.
// ----------------------------------------------------------------------------
module crc16_byte_stream_engine_test;

  localparam int unsigned      ClkPeriodNs     = 10;
  localparam int unsigned      ResetCycles     = 5;
  localparam int unsigned      DrainCycles     = 8;
  localparam int unsigned      LongStallCycles = 300;
  localparam int unsigned      ItemsPerPhase   = 250;
  localparam int unsigned      MaxReported     = 10;
  localparam int unsigned      TimeoutNs       = 5_000_000;
  localparam crcbse_pkg::crc_t GenPoly         = 16'h1021;

  logic clk;
  logic rst_n;

  crcbse_in_if  in_ch ();
  crcbse_out_if out_ch ();

  crc16_byte_stream_engine dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  crcbse_pkg::crc_t crc_state          = '0;
  crcbse_pkg::res_t expected_results[$];
  int unsigned      bytes_sent         = 0;
  int unsigned      mismatch_count     = 0;
  int unsigned      send_idle_pct      = 0;
  int unsigned      recv_idle_pct      = 0;
  int unsigned      stall_cycles_left  = 0;

  function automatic crcbse_pkg::crc_t advance_crc(crcbse_pkg::crc_t rem,
                                                   crcbse_pkg::byte_t data);
    crcbse_pkg::crc_t r;
    logic msb;
    r = rem;
    for (int i = crcbse_pkg::ByteWidth - 1; i >= 0; i--) begin
      msb = r[crcbse_pkg::CrcWidth-1];
      r = {r[crcbse_pkg::CrcWidth-2:0], data[i]};
      if (msb) begin
        r = r ^ GenPoly;
      end
    end
    return r;
  endfunction

  task automatic report_fail(string msg);
    mismatch_count++;
    if (mismatch_count <= MaxReported) begin
      $display("%s", msg);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #(ClkPeriodNs / 2) clk = ~clk;
  end

  initial begin
    #(TimeoutNs);
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin : result_check
    crcbse_pkg::res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_fail($sformatf("unexpected result: crc_value=%h crc_is_zero=%b",
                              out_ch.crc_value, out_ch.crc_is_zero));
      end else begin
        want = expected_results.pop_front();
        if (out_ch.crc_value !== want.crc_value || out_ch.crc_is_zero !== want.crc_is_zero)
        begin
          report_fail($sformatf("mismatch: expected crc_value=%h crc_is_zero=%b, got %h %b",
                                want.crc_value, want.crc_is_zero,
                                out_ch.crc_value, out_ch.crc_is_zero));
        end
      end
    end
    if (stall_cycles_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_cycles_left--;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_byte(crcbse_pkg::byte_t data, logic is_start, logic is_last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= data;
    in_ch.start_flag <= is_start;
    in_ch.last_byte  <= is_last;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    if (is_start) begin
      crc_state = '0;
    end
    crc_state = advance_crc(crc_state, data);
    if (is_last) begin
      expected_results.push_back(crcbse_pkg::res_t'{crc_value: crc_state,
                                                    crc_is_zero: crc_state == '0});
    end
    bytes_sent++;
  endtask

  // Hold the input until every pending result has been taken.
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Append two bytes that bring the remainder to zero, as an intact image does.
  task automatic send_message(int unsigned len, bit with_start, bit with_check);
    crcbse_pkg::crc_t tail;
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(crcbse_pkg::byte_t'($urandom_range(0, 255)), with_start && i == 0,
                !with_check && i == len - 1);
    end
    if (with_check) begin
      tail = advance_crc(advance_crc(crc_state, 8'h00), 8'h00);
      send_byte(tail[15:8], 1'b0, 1'b0);
      send_byte(tail[7:0], 1'b0, 1'b1);
    end
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_byte(8'h12, 1'b0, 1'b0);
    send_byte(8'h34, 1'b0, 1'b1);
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(8'h80, 1'b1, 1'b1);
    send_byte(8'h01, 1'b1, 1'b1);
    send_byte(8'hA5, 1'b0, 1'b1);
    send_byte(8'h5A, 1'b0, 1'b0);
    send_byte(8'hC3, 1'b0, 1'b1);
    send_byte(8'h11, 1'b1, 1'b0);
    send_byte(8'h22, 1'b1, 1'b0);
    send_byte(8'h33, 1'b0, 1'b1);
    send_byte(8'h31, 1'b1, 1'b0);
    send_byte(8'h32, 1'b0, 1'b0);
    send_byte(8'h33, 1'b0, 1'b0);
    send_message(0, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    wait_for_results();
  endtask

  task automatic test_output_stall();
    send_idle_pct     = 0;
    recv_idle_pct     = 0;
    stall_cycles_left = LongStallCycles;
    repeat (40) begin
      send_byte(crcbse_pkg::byte_t'($urandom_range(0, 255)), 1'b1, 1'b1);
    end
    wait_for_results();
  endtask

  task automatic run_random_traffic(int unsigned snd_pct, int unsigned rcv_pct);
    int unsigned target;
    int unsigned pick;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    target = bytes_sent + ItemsPerPhase;
    while (bytes_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        repeat (4) begin
          send_byte(crcbse_pkg::byte_t'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                    $urandom_range(0, 2) == 0);
        end
      end else if (pick < 30) begin
        send_message($urandom_range(0, 6), $urandom_range(0, 4) != 0, 1'b1);
      end else if (pick < 45) begin
        send_message(1, 1'b1, 1'b0);
      end else begin
        send_message($urandom_range(1, 8), $urandom_range(0, 9) != 0, 1'b0);
      end
    end
    wait_for_results();
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.data_byte  <= '0;
    in_ch.start_flag <= 1'b0;
    in_ch.last_byte  <= 1'b0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    run_random_traffic(7, 69);
    test_output_stall();
    run_random_traffic(69, 7);
    run_random_traffic(0, 0);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/crcbse_pkg.sv
hw/rtl/crcbse_if.sv
hw/rtl/crcbse_core.sv
hw/rtl/crcbse_out_reg.sv
hw/rtl/crc16_byte_stream_engine.sv
bench/crc16_byte_stream_engine_test.sv
